// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL unit integer_to_radix_digits_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/itrd_pkg.sv =====
// Package for the integer to radix digits unit: states, register indexes, constants.
package itrd_pkg;

  localparam int SYM_W = 8;

  // Sign byte sent ahead of a negative value
  localparam logic [SYM_W-1:0] MINUS_SYMBOL = 8'h2D;

  // Configuration register indexes
  localparam logic [1:0] CFG_RADIX     = 2'd0;
  localparam logic [1:0] CFG_SYM_LOWER = 2'd1;
  localparam logic [1:0] CFG_SYM_UPPER = 2'd2;

  // Register reset values
  localparam logic [4:0]  RADIX_RST     = 5'd10;
  localparam logic [63:0] SYM_LOWER_RST = 64'h3736353433323130;
  localparam logic [63:0] SYM_UPPER_RST = 64'h4645444342413938;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH
  } state_t;

endpackage

// ===== rtl/integer_to_radix_digits_unit.sv =====
// Integer to radix digits unit: bit-serial division with a digit stack and symbol output.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+---------------------------------
//   input    | start, busy, in_value              | taken when start & !busy
//   result   | out_valid, out_symbol, out_last    | one-cycle strobe, no backpressure
//   config   | cfg_we, cfg_index, cfg_data        | written when cfg_we is high
//
// Each digit comes from the restoring remainder loop (one quotient bit per cycle);
// digits stop once the quotient reaches zero. Output then sends the minus sign for a
// negative value, then reads each digit from the stack and strobes its symbol.
// Reset is synchronous on rst_n; the receiver cannot stall, so results are never held.
`include "assert_macros.svh"

module integer_to_radix_digits_unit
  import itrd_pkg::*;
#(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transaction
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  // result transaction
  output logic                         out_valid,
  output logic [SYM_W-1:0]             out_symbol,
  output logic                         out_last,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [63:0]                  cfg_data
);

  localparam int VB = VALUE_BITS;
  localparam int DW = $clog2(MAX_RADIX);   // digit width
  localparam int RW = DW + 1;              // radix / trial remainder width
  localparam int AW = $clog2(VB);          // digit stack address
  localparam int CW = $clog2(VB + 1);      // digit count

  // Configuration registers
  logic [4:0]  radix_r;
  logic [63:0] sym_lower_r;
  logic [63:0] sym_upper_r;

  // Control and datapath registers
  state_t          state_r, state_nxt;
  logic [VB-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   radix_eff_r, radix_eff_nxt;
  logic            neg_r, neg_nxt;
  logic [AW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]   ndig_r, ndig_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic            out_last_r, out_last_nxt;
  logic            emit_r, emit_nxt;

  // Digit stack
  logic [DW-1:0]   dig_mem [VB];
  logic [DW-1:0]   rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [DW-1:0]   wr_data;

  // Combinational helpers
  logic            accept;
  logic [4:0]      radix_clamp;
  logic [VB-1:0]   vin, mag_in;
  logic [RW-1:0]   trial;
  logic            ge;
  logic [RW-1:0]   trial_sub;
  logic [127:0]    sym_tab;
  logic [3:0]      sym_idx;
  logic [SYM_W-1:0] sym_byte;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Saturate the configured radix into the supported range
  always_comb begin
    if (radix_r < 5'd2) begin
      radix_clamp = 5'd2;
    end else if (radix_r > 5'(MAX_RADIX)) begin
      radix_clamp = 5'(MAX_RADIX);
    end else begin
      radix_clamp = radix_r;
    end
  end

  // Magnitude as unsigned, so the most negative value converts too
  assign vin    = in_value;
  assign mag_in = vin[VB-1] ? (~vin + VB'(1)) : vin;

  // One restoring division step: shift in the next quotient bit
  assign trial     = {rem_r, quo_r[VB-1]};
  assign ge        = (trial >= radix_eff_r);
  assign trial_sub = trial - radix_eff_r;

  // Symbol lookup from the stacked digit
  assign sym_tab  = {sym_upper_r, sym_lower_r};
  assign sym_idx  = 4'(rd_data_r);
  assign sym_byte = sym_tab[{sym_idx, 3'b000} +: SYM_W];

  // Next state and outputs
  always_comb begin
    state_nxt      = state_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    radix_eff_nxt  = radix_eff_r;
    neg_nxt        = neg_r;
    bit_cnt_nxt    = bit_cnt_r;
    ndig_nxt       = ndig_r;
    out_valid_nxt  = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    emit_nxt       = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    wr_addr        = ndig_r[AW-1:0];
    wr_data        = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
    rd_addr        = AW'(ndig_r - CW'(1));

    // Symbol strobe for the digit read in the previous cycle
    if (emit_r) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = sym_byte;
      out_last_nxt   = (ndig_r == CW'(1));
      ndig_nxt       = ndig_r - CW'(1);
      state_nxt      = (ndig_r == CW'(1)) ? ST_IDLE : ST_FETCH;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            quo_nxt       = mag_in;
            rem_nxt       = '0;
            radix_eff_nxt = radix_clamp[RW-1:0];
            neg_nxt       = vin[VB-1];
            bit_cnt_nxt   = '0;
            ndig_nxt      = '0;
            state_nxt     = ST_DIV;
          end
        end
        ST_DIV: begin
          quo_nxt = {quo_r[VB-2:0], ge};
          rem_nxt = wr_data;
          if (bit_cnt_r == AW'(VB - 1)) begin
            // digit done: push remainder, restart on the quotient
            mem_we      = 1'b1;
            ndig_nxt    = ndig_r + CW'(1);
            rem_nxt     = '0;
            bit_cnt_nxt = '0;
            if ({quo_r[VB-2:0], ge} == '0) begin
              state_nxt = neg_r ? ST_SIGN : ST_FETCH;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + AW'(1);
          end
        end
        ST_SIGN: begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = MINUS_SYMBOL;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_FETCH;
        end
        ST_FETCH: begin
          // read the most significant remaining digit
          mem_re   = 1'b1;
          emit_nxt = 1'b1;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      emit_r      <= 1'b0;
      radix_r     <= RADIX_RST;
      sym_lower_r <= SYM_LOWER_RST;
      sym_upper_r <= SYM_UPPER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      emit_r      <= emit_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIX:     radix_r     <= cfg_data[4:0];
          CFG_SYM_LOWER: sym_lower_r <= cfg_data;
          CFG_SYM_UPPER: sym_upper_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    radix_eff_r  <= radix_eff_nxt;
    neg_r        <= neg_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    ndig_r       <= ndig_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Digit stack: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dig_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= dig_mem[rd_addr];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  // Checks
  `AST_IMPLY(a_last_ends_run, out_valid_r && out_last_r, state_r == ST_IDLE,
             "final symbol while conversion still running")
  `AST_NEXT(a_accept_starts, accept, state_r == ST_DIV && ndig_r == '0,
            "transaction accepted but division not started")
  `AST_IMPLY(a_fetch_has_digit, state_r == ST_FETCH, ndig_r != '0,
             "stack read with no digit left")
  `AST_IMPLY(a_strobe_source, out_valid_r,
             $past(state_r) == ST_SIGN || $past(emit_r),
             "result strobe without sign or digit emission")

endmodule

// ===== test/integer_to_radix_digits_unit_tb.sv =====
// Testbench for integer_to_radix_digits_unit: random and directed conversions checked by a scoreboard.
module integer_to_radix_digits_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itrd_pkg::*;

  localparam int VALUE_BITS = 63;
  localparam int MAX_RADIX  = 16;
  localparam int PHASES     = 7;
  localparam int PHASE_ITEMS = 15;
  // worst item: a full-width radix-2 conversion plus a long sender gap, times several
  localparam int unsigned RUN_LIMIT = 6_000_000;
  localparam int unsigned END_WAIT  = 200;

  // register index that the block does not decode
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } text_char_t;

  // Expected character stream, built per accepted value
  class radix_text_scoreboard;
    text_char_t chars_q[$];
    logic [4:0]  radix;
    logic [63:0] sym_lower;
    logic [63:0] sym_upper;
    int          errors;

    function new();
      radix     = RADIX_RST;
      sym_lower = SYM_LOWER_RST;
      sym_upper = SYM_UPPER_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_RADIX:     radix     = data[4:0];
        CFG_SYM_LOWER: sym_lower = data;
        CFG_SYM_UPPER: sym_upper = data;
        default: ;
      endcase
    endfunction

    function logic [SYM_W-1:0] digit_char(logic [3:0] d);
      logic [63:0] word;
      word = d[3] ? sym_upper : sym_lower;
      return word[d[2:0]*8 +: 8];
    endfunction

    // note an accepted value: queue its sign and digits, most significant first
    function void note_value(logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] base;
      logic [3:0]            digits_q[$];
      logic                  neg;
      int unsigned           eff;
      eff = radix;
      if (eff < 2) eff = 2;
      if (eff > MAX_RADIX) eff = MAX_RADIX;
      base = VALUE_BITS'(eff);
      neg = value[VALUE_BITS-1];
      mag = neg ? (~value + 1'b1) : value;
      if (mag == '0) begin
        digits_q.push_back(4'd0);
        neg = 1'b0;
      end else begin
        while (mag != '0) begin
          digits_q.push_front(4'(mag % base));
          mag = mag / base;
        end
      end
      if (neg) chars_q.push_back('{symbol: MINUS_SYMBOL, last: 1'b0});
      foreach (digits_q[i]) chars_q.push_back('{symbol: digit_char(digits_q[i]), last: 1'b0});
      chars_q[chars_q.size()-1].last = 1'b1;
    endfunction

    function void check_char(logic [SYM_W-1:0] symbol, logic last);
      text_char_t exp_c;
      if (chars_q.size() == 0) begin
        $error("unexpected character: symbol %h last %b", symbol, last);
        errors++;
        return;
      end
      exp_c = chars_q.pop_front();
      if (symbol !== exp_c.symbol) begin
        $error("symbol: expected %h, got %h", exp_c.symbol, symbol);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last: expected %b, got %b", exp_c.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return chars_q.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic [SYM_W-1:0]             out_symbol;
  logic                         out_last;
  logic                         cfg_we;
  logic [1:0]                   cfg_index;
  logic [63:0]                  cfg_data;

  radix_text_scoreboard sb = new();
  logic        start_hi = 1'b0;
  int unsigned cycle_count = 0;

  // sender idle percentage per random phase
  int unsigned idle_pct [PHASES] = '{0, 63, 18, 63, 0, 18, 63};

  logic [VALUE_BITS-1:0] directed_values [16] = '{
    '0, 63'd1, -63'sd1, 63'd7, 63'd9, 63'd10, -63'sd10, 63'd100,
    VALUE_MAX, VALUE_MIN, VALUE_MIN + 1'b1,
    63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
    63'd999_999_999_999_999_999, -63'sd1_000_000_000_000_000_000, 63'd12345
  };

  integer_to_radix_digits_unit #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_symbol(out_symbol),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("integer_to_radix_digits_unit_tb: FAIL");
      $finish;
    end
  end

  // result monitor: every strobe is a transaction
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_char(out_symbol, out_last);
  end

  // random value: full width, random bit length, or small magnitude
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [63:0]           raw;
    logic [VALUE_BITS-1:0] v;
    int unsigned           nbits;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(3))
      0: v = raw[VALUE_BITS-1:0];
      3: v = VALUE_BITS'($urandom_range(300));
      default: begin
        nbits = $urandom_range(1, VALUE_BITS - 1);
        v = raw[VALUE_BITS-1:0] >> (VALUE_BITS - nbits);
      end
    endcase
    if (v != VALUE_MIN && $urandom_range(1)) v = -v;
    return v;
  endfunction

  // one input transaction, after an optional sender gap
  task automatic send_value(logic [VALUE_BITS-1:0] v, int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) gap++;
      // now and then a long gap so that start lands on every phase of the work
      if ($urandom_range(9) == 0) gap = $urandom_range(1, 4500);
    end
    if (gap != 0) begin
      if (start_hi) start <= 1'b0;
      start_hi = 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    start_hi = 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    sb.note_value(v);
  endtask

  // hold off until every expected character has come and the block is idle
  task automatic wait_idle();
    if (start_hi) start <= 1'b0;
    start_hi = 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // per-phase register settings, extremes first
  task automatic load_phase_config(int p);
    logic [4:0]  radix_sel;
    logic [63:0] lower;
    logic [63:0] upper;
    logic [63:0] noise;
    lower = {$urandom(), $urandom()};
    upper = {$urandom(), $urandom()};
    noise = {$urandom(), $urandom()};
    case (p)
      0: begin
        radix_sel = 5'd2;
        lower = '0;
        upper = '1;
      end
      1: radix_sel = 5'd16;
      2: radix_sel = 5'd0;
      3: begin
        radix_sel = 5'd31;
        lower = SYM_LOWER_RST;
        upper = SYM_UPPER_RST;
      end
      4: radix_sel = 5'd1;
      5: begin
        radix_sel = 5'd17;
        lower[7:0] = MINUS_SYMBOL;
      end
      default: radix_sel = 5'($urandom_range(3, 15));
    endcase
    // upper data bits are don't-care for the radix register
    write_reg(CFG_RADIX, {noise[63:5], radix_sel});
    write_reg(CFG_SYM_LOWER, lower);
    write_reg(CFG_SYM_UPPER, upper);
    if (p == 4) write_reg(CFG_UNUSED, noise);
    cfg_we <= 1'b0;
  endtask

  initial begin
    start     <= 1'b0;
    in_value  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_RADIX;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed values on the reset alphabet and radix
    foreach (directed_values[i]) send_value(directed_values[i], 0);

    // random phases, each with its own radix, alphabet and sender idling
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      load_phase_config(p);
      send_value(VALUE_MIN, idle_pct[p]);
      send_value('0, idle_pct[p]);
      send_value(VALUE_MAX, idle_pct[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) wait_idle();
        send_value(random_value(), idle_pct[p]);
      end
    end

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("integer_to_radix_digits_unit_tb: PASS");
    end else begin
      $display("integer_to_radix_digits_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
